// ===== design/arcr_pkg.sv =====
// Shared types and constants for the address range conflict register.
`timescale 1ns / 1ps
`default_nettype none
package arcr_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam int ADDR_W    = 64;
  localparam int END_W     = ADDR_W + 1;
  localparam int ENTRY_W   = ADDR_W + END_W;
  localparam int STATUS_W  = 2;
  localparam int HIT_W     = 6;
  localparam int USED_W    = 7;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_CONFLICT = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage
`default_nettype wire

// ===== design/arcr_ram.sv =====
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arcr_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 129
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/arcr_cmp.sv =====
// Half-open overlap test of a new region against one stored region.
`timescale 1ns / 1ps
`default_nettype none
module arcr_cmp
  import arcr_pkg::*;
(
  input  wire logic [ADDR_W-1:0] new_base,
  input  wire logic [END_W-1:0]  new_end,
  input  wire logic [ENTRY_W-1:0] entry,
  output logic                   hit
);

  logic [ADDR_W-1:0] old_base;
  logic [END_W-1:0]  old_end;

  assign old_base = entry[ENTRY_W-1:END_W];
  assign old_end  = entry[END_W-1:0];

  assign hit = (old_end > {1'b0, new_base}) && (new_end > {1'b0, old_base});

endmodule
`default_nettype wire

// ===== design/address_range_conflict_register_core.sv =====
// Top level: region table walk and result register.
//
//   channel   signals                                   dir  handshake
//   command   start, busy, region_base, region_size     in   start & !busy
//   result    done, status, conflict_index,             out  done, one cycle
//             entries_used
//
// An ignored or full item answers in the cycle after it is taken.
// Otherwise the stored entries are read one per cycle from the table memory.
// busy stays high for the walk; done comes in the cycle busy falls.
// rst is synchronous and empties the table; no clearing pass is needed.
// Results cannot be stalled; each is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module address_range_conflict_register_core
  import arcr_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ADDR_W-1:0]   region_base,
  input  wire logic [ADDR_W-1:0]   region_size,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [HIT_W-1:0]         conflict_index,
  output logic [USED_W-1:0]        entries_used
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [ADDR_W-1:0] base_q;
  logic [END_W-1:0]  end_q;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rd_idx;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;

  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic              finish;
  status_t           fin_status;
  logic              hit;
  logic [ENTRY_W-1:0] rd_data;

  logic [IDX_W+HIT_W-1:0]  hit_ext;
  logic [CNT_W+USED_W-1:0] used_ext;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  arcr_ram #(
    .DEPTH(TABLE_DEPTH),
    .AW   (IDX_W),
    .DW   (ENTRY_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data({base_q, end_q}),
    .rd_en  (rd_en),
    .rd_addr(rd_idx[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  arcr_cmp u_cmp (
    .new_base(base_q),
    .new_end (end_q),
    .entry   (rd_data),
    .hit     (hit)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && region_base != '0 && region_size != '0 &&
            count != CNT_W'(TABLE_DEPTH)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((pend && hit) || (!pend && rd_idx == count)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    finish     = 1'b0;
    fin_status = ST_STORED;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (region_base == '0 || region_size == '0) begin
            finish     = 1'b1;
            fin_status = ST_IGNORED;
          end else if (count == CNT_W'(TABLE_DEPTH)) begin
            finish     = 1'b1;
            fin_status = ST_FULL;
          end
        end
      end
      S_SCAN: begin
        if (pend && hit) begin
          finish     = 1'b1;
          fin_status = ST_CONFLICT;
        end else if (!pend && rd_idx == count) begin
          finish     = 1'b1;
          wr_en      = 1'b1;
          fin_status = ST_STORED;
        end else if (rd_idx != count) begin
          rd_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign count_next = wr_en ? count + 1'b1 : count;
  assign hit_ext    = (IDX_W + HIT_W)'(pend_idx);
  assign used_ext   = (CNT_W + USED_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
      pend  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_q <= region_base;
      end_q  <= {1'b0, region_base} + {1'b0, region_size};
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (rd_en) begin
      pend_idx <= rd_idx[IDX_W-1:0];
    end
    if (finish) begin
      status         <= fin_status;
      conflict_index <= (fin_status == ST_CONFLICT) ? hit_ext[HIT_W-1:0] : '0;
      entries_used   <= used_ext[USED_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/arcr_chk.sv =====
// Port-level checks for the address range conflict register, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arcr_chk
  import arcr_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [ADDR_W-1:0]   region_base,
  input wire logic [ADDR_W-1:0]   region_size,
  input wire logic                done,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [HIT_W-1:0]    conflict_index,
  input wire logic [USED_W-1:0]   entries_used
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_zero_ignored: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (region_base == '0 || region_size == '0))
      |=> (done && status == ST_IGNORED))
    else $error("zero region not answered as ignored");

  a_index_clear: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_CONFLICT) |-> (conflict_index == '0))
    else $error("conflict index set without conflict");

  a_stored_used: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_STORED) |-> (entries_used != '0))
    else $error("stored word left the table empty");

endmodule

bind address_range_conflict_register_core arcr_chk u_arcr_chk (.*);
`default_nettype wire
